// ===== src/sdle_pkg.sv =====
// Shared constants, payload types and cell control types for the sorted deque list engine.
package sdle_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         count_t;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_INSERT     = 3'd2;
  localparam logic [2:0] OP_REMOVE     = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;

  localparam logic [2:0] STAT_DONE     = 3'd0;
  localparam logic [2:0] STAT_FULL     = 3'd1;
  localparam logic [2:0] STAT_NOTFOUND = 3'd2;
  localparam logic [2:0] STAT_EMPTY    = 3'd3;
  localparam logic [2:0] STAT_DATA     = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    word_t      value;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    word_t      element;
    logic       last;
  } res_t;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_FRONT,
    CM_BACK,
    CM_SORT,
    CM_REMOVE,
    CM_ROTATE
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    word_t      value;
  } cell_ctl_t;

  typedef enum logic {
    SM_IDLE,
    SM_READ
  } state_t;

endpackage

// ===== src/sdle_cell.sv =====
// One storage cell of the list: holds a word and shifts with its neighbours.
module sdle_cell (
  input  logic              clk,
  input  sdle_pkg::cell_ctl_t ctl,
  input  logic              first,
  input  logic              occ,
  input  logic              is_tail,
  input  sdle_pkg::word_t   left_word,
  input  sdle_pkg::word_t   right_word,
  input  sdle_pkg::word_t   head_word,
  input  logic              hit_in,
  output logic              hit_out,
  output sdle_pkg::word_t   word
);
  import sdle_pkg::*;

  logic  my_hit;
  word_t word_next;

  // my_hit marks the insertion or removal point; hit_in says it lies further up the chain
  always_comb begin
    case (ctl.mode)
      CM_FRONT:  my_hit = first;
      CM_BACK:   my_hit = !occ;
      CM_SORT:   my_hit = !occ || !(word < ctl.value);
      CM_REMOVE: my_hit = occ && (word == ctl.value);
      default:   my_hit = 1'b0;
    endcase
    hit_out = hit_in || my_hit;

    word_next = word;
    case (ctl.mode)
      CM_FRONT, CM_BACK, CM_SORT: begin
        if (hit_in) begin
          word_next = left_word;
        end else if (my_hit) begin
          word_next = ctl.value;
        end
      end
      CM_REMOVE: begin
        if (hit_out) begin
          word_next = right_word;
        end
      end
      CM_ROTATE: begin
        word_next = is_tail ? head_word : right_word;
      end
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ===== src/sorted_deque_list_engine.sv =====
// Top level: row of list cells, element count, command decode and result register.
// Pushes, sorted inserts and removes take effect when accepted: every cell
// compares against the broadcast value and shifts at once, the insertion point
// travelling down the row as a hit flag. A read out sends the elements from the
// head, stalling while results are held, as the row rotates left so the head is
// always cell 0; no new word is taken until the read out is over. A word is
// accepted only when the result register is free or being emptied in that cycle.
module sorted_deque_list_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  sdle_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output sdle_pkg::res_t res
);
  import sdle_pkg::*;

  state_t    state, state_next;
  count_t    count, count_next;
  count_t    rd_idx, rd_idx_next;
  logic      res_valid_next;
  res_t      res_next;
  logic      res_load;
  logic      out_free;
  logic      accept;
  logic      full;
  cell_ctl_t ctl;

  logic  hit   [CAPACITY+1];
  word_t words [CAPACITY];

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sdle_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .first      (i == 0),
      .occ        (count > CNT_W'(i)),
      .is_tail    ((count - count_t'(1)) == CNT_W'(i)),
      .left_word  (words[(i == 0) ? 0 : i - 1]),
      .right_word (words[(i == CAPACITY - 1) ? i : i + 1]),
      .head_word  (words[0]),
      .hit_in     (hit[i]),
      .hit_out    (hit[i+1]),
      .word       (words[i])
    );
  end

  assign full     = (count == CNT_W'(CAPACITY));
  assign out_free = !res_valid || res_ready;
  assign cmd_ready = (state == SM_IDLE) && out_free;
  assign accept   = cmd_valid && cmd_ready;

  always_comb begin
    state_next       = state;
    count_next       = count;
    rd_idx_next      = rd_idx;
    res_load         = 1'b0;
    res_next.status  = STAT_DONE;
    res_next.element = '0;
    res_next.last    = 1'b1;
    ctl.mode         = CM_HOLD;
    ctl.value        = cmd.value;

    case (state)
      SM_IDLE: begin
        if (accept) begin
          case (cmd.op)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
              res_load = 1'b1;
              if (full) begin
                res_next.status = STAT_FULL;
              end else begin
                count_next = count + count_t'(1);
                case (cmd.op)
                  OP_PUSH_FRONT: ctl.mode = CM_FRONT;
                  OP_PUSH_BACK:  ctl.mode = CM_BACK;
                  default:       ctl.mode = CM_SORT;
                endcase
              end
            end
            OP_REMOVE: begin
              res_load = 1'b1;
              if (count == '0) begin
                res_next.status = STAT_EMPTY;
              end else begin
                ctl.mode = CM_REMOVE;
                if (hit[CAPACITY]) begin
                  count_next = count - count_t'(1);
                end else begin
                  res_next.status = STAT_NOTFOUND;
                end
              end
            end
            OP_READ: begin
              if (count == '0) begin
                res_load        = 1'b1;
                res_next.status = STAT_EMPTY;
              end else begin
                rd_idx_next = '0;
                state_next  = SM_READ;
              end
            end
            default: ;
          endcase
        end
      end
      SM_READ: begin
        if (out_free) begin
          res_load         = 1'b1;
          res_next.status  = STAT_DATA;
          res_next.element = words[0];
          res_next.last    = (rd_idx == count - count_t'(1));
          ctl.mode         = CM_ROTATE;
          rd_idx_next      = rd_idx + count_t'(1);
          if (res_next.last) begin
            state_next = SM_IDLE;
          end
        end
      end
      default: state_next = SM_IDLE;
    endcase

    if (res_load) begin
      res_valid_next = 1'b1;
    end else if (res_ready) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SM_IDLE;
      count     <= '0;
      rd_idx    <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rd_idx    <= rd_idx_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

endmodule

// ===== sim/sorted_deque_list_engine_tb.sv =====
// Self-checking testbench for the sorted deque list engine: random bursts, stalls and a list model.
`timescale 1ns / 100ps

module sorted_deque_list_engine_tb;
  import sdle_pkg::*;

  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  localparam word_t W_MIN = 32'sh8000_0000;
  localparam word_t W_MAX = 32'sh7FFF_FFFF;

  localparam int N_RANDOM   = 400;
  localparam int HOLD_LEN   = 250;
  localparam int HOLD_AFTER = 150;
  localparam int TAIL_WAIT  = 40;
  localparam int MAX_PRINT  = 50;

  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIX, SEG_SORTED} seg_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic clk;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic res_ready = 1'b0;
  cmd_t cmd       = '0;
  logic cmd_ready;
  logic res_valid;
  res_t res;

  cmd_t  pending_q[$];
  res_t  due_res_q[$];
  word_t shadow_list[$];
  word_t pushed_hist[$];
  word_t value_pool[6];

  int n_err      = 0;
  int n_accepted = 0;
  int burst_left = 0;
  int gap_left   = 0;
  int rx_cycle   = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;
  rx_mode_e rx_mode = RX_OPEN;
  res_t want;

  sorted_deque_list_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("sorted_deque_list_engine regression: fail");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    if (n_err < MAX_PRINT)
      $display("[%0t] mismatch: %s", $realtime, msg);
    n_err++;
  endtask

  // Apply one word to the list copy and queue the results it should produce.
  task automatic advance_list(input cmd_t c);
    int   pos;
    res_t r;
    r      = '0;
    r.last = 1'b1;
    case (c.op)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
        if (shadow_list.size() >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          r.status = STAT_DONE;
          if (c.op == OP_PUSH_FRONT) begin
            shadow_list.push_front(c.value);
          end else if (c.op == OP_PUSH_BACK) begin
            shadow_list.push_back(c.value);
          end else begin
            pos = 0;
            while (pos < shadow_list.size() && shadow_list[pos] < c.value)
              pos++;
            shadow_list.insert(pos, c.value);
          end
        end
        due_res_q.push_back(r);
      end
      OP_REMOVE: begin
        if (shadow_list.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          pos = 0;
          while (pos < shadow_list.size() && shadow_list[pos] != c.value)
            pos++;
          if (pos == shadow_list.size()) begin
            r.status = STAT_NOTFOUND;
          end else begin
            shadow_list.delete(pos);
            r.status = STAT_DONE;
          end
        end
        due_res_q.push_back(r);
      end
      OP_READ: begin
        if (shadow_list.size() == 0) begin
          r.status = STAT_EMPTY;
          due_res_q.push_back(r);
        end else begin
          for (int i = 0; i < shadow_list.size(); i++) begin
            r.status  = STAT_DATA;
            r.element = shadow_list[i];
            r.last    = (i == shadow_list.size() - 1);
            due_res_q.push_back(r);
          end
        end
      end
      default: ;  // spare codes are ignored
    endcase
  endtask

  task automatic add_item(input logic [2:0] op, input word_t value);
    cmd_t c;
    c.op    = op;
    c.value = value;
    pending_q.push_back(c);
    if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK || op == OP_INSERT) begin
      pushed_hist.push_back(value);
      if (pushed_hist.size() > 32)
        void'(pushed_hist.pop_front());
    end
  endtask

  function automatic word_t pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0: return W_MIN;
        1: return W_MAX;
        2: return 32'sd0;
        3: return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    if (r <= 5)
      return value_pool[$urandom_range(0, 5)];
    return word_t'($urandom);
  endfunction

  // Mostly values pushed recently, so removes are likely to hit.
  function automatic word_t pick_remove_value();
    if (pushed_hist.size() != 0 && $urandom_range(0, 99) < 85)
      return pushed_hist[$urandom_range(0, pushed_hist.size() - 1)];
    return pick_value();
  endfunction

  // Stimulus generation and end of run
  initial begin
    seg_e       seg;
    int         seg_len;
    int         n_random;
    int         r;
    logic [2:0] op;

    for (int i = 0; i < 6; i++)
      value_pool[i] = word_t'($urandom);
    value_pool[5] = value_pool[4] + 32'sd1;

    // directed opening
    add_item(OP_READ, 32'sd0);
    add_item(OP_REMOVE, 32'sd0);
    add_item(OP_PUSH_FRONT, W_MAX);
    add_item(OP_PUSH_BACK, W_MIN);
    add_item(OP_INSERT, 32'sd0);
    add_item(OP_INSERT, 32'sd0);
    add_item(OP_INSERT, -32'sd1);
    add_item(OP_INSERT, W_MAX);
    add_item(OP_READ, 32'sh1234_5678);
    add_item(OP_REMOVE, 32'sd5);
    add_item(OP_REMOVE, W_MIN);
    add_item(OP_REMOVE, 32'sd0);
    add_item(OP_SPARE_A, W_MAX);
    add_item(OP_SPARE_B, W_MIN);
    add_item(OP_SPARE_C, -32'sd1);
    add_item(OP_READ, 32'sd0);
    add_item(OP_REMOVE, W_MAX);
    add_item(OP_REMOVE, 32'sd0);
    add_item(OP_REMOVE, -32'sd1);
    add_item(OP_REMOVE, W_MAX);
    add_item(OP_READ, 32'sd0);
    add_item(OP_INSERT, 32'sh5555_5555);
    add_item(OP_PUSH_FRONT, 32'shAAAA_AAAA);
    add_item(OP_READ, W_MIN);

    // random segments, the first one filling the list past capacity
    n_random = 0;
    seg      = SEG_FILL;
    while (n_random < N_RANDOM) begin
      seg_len = (seg == SEG_FILL) ? $urandom_range(20, 26) : $urandom_range(8, 30);
      for (int k = 0; k < seg_len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          add_item(3'($urandom_range(5, 7)), word_t'($urandom));
          continue;
        end
        case (seg)
          SEG_FILL:   op = (r < 35) ? OP_PUSH_BACK : (r < 60) ? OP_PUSH_FRONT :
                           (r < 93) ? OP_INSERT : (r < 98) ? OP_READ : OP_REMOVE;
          SEG_DRAIN:  op = (r < 72) ? OP_REMOVE : (r < 87) ? OP_READ :
                           (r < 94) ? OP_INSERT : OP_PUSH_BACK;
          SEG_SORTED: op = (r < 85) ? OP_INSERT : (r < 93) ? OP_READ : OP_REMOVE;
          default:    op = (r < 20) ? OP_PUSH_FRONT : (r < 35) ? OP_PUSH_BACK :
                           (r < 50) ? OP_INSERT : (r < 80) ? OP_REMOVE : OP_READ;
        endcase
        add_item(op, (op == OP_REMOVE) ? pick_remove_value() : pick_value());
        n_random++;
      end
      seg = seg_e'($urandom_range(0, 3));
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || cmd_valid)
      @(posedge clk);
    while (due_res_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (due_res_q.size() != 0)
      flag_mismatch($sformatf("%0d expected words never arrived", due_res_q.size()));

    if (n_err == 0) begin
      $display("sorted_deque_list_engine regression: pass");
    end else begin
      $display("sorted_deque_list_engine regression: fail");
    end
    $finish;
  end

  // Command driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      cmd       <= '0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        advance_list(cmd);
        n_accepted++;
      end
      if (!cmd_valid || cmd_ready) begin
        if (gap_left > 0 || pending_q.size() == 0) begin
          if (gap_left > 0)
            gap_left--;
          cmd_valid <= 1'b0;
        end else begin
          cmd       <= pending_q.pop_front();
          cmd_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // Result receiver: stall pattern redrawn at random from four modes as rx_cycle runs, plus one long hold
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        res_ready <= 1'b0;
      end else begin
        if (rx_cycle % 64 == 0)
          rx_mode = rx_mode_e'($urandom_range(0, 3));
        case (rx_mode)
          RX_OPEN:   res_ready <= 1'b1;
          RX_COIN:   res_ready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: res_ready <= ($urandom_range(0, 3) == 0);
          default:   res_ready <= (rx_cycle % 5 != 0);
        endcase
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (due_res_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected word status=%0d element=%0d last=%0b",
                                res.status, res.element, res.last));
      end else begin
        want = due_res_q.pop_front();
        if (res.status !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", res.status, want.status));
        if (res.element !== want.element)
          flag_mismatch($sformatf("element %0d, want %0d", res.element, want.element));
        if (res.last !== want.last)
          flag_mismatch($sformatf("last %0b, want %0b", res.last, want.last));
      end
    end
  end

endmodule

// ===== sorted_deque_list_engine.f =====
src/sdle_pkg.sv
src/sdle_cell.sv
src/sorted_deque_list_engine.sv
sim/sorted_deque_list_engine_tb.sv
